// ===== rtl/chol_pkg.sv =====
// Shared types and constants for the Cholesky factorization block.
// No dependencies; used by chol_sqdiv and cholesky_decomposition.
`timescale 1ns / 1ps
`default_nettype none
package chol_pkg;

   localparam int IDX_W   = 4;   // row/col/size counter width (4 bits hold 0..15)
   localparam int DATA_W  = 32;
   localparam int WIDE_W  = 64;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOT_SYM = 2'd1;
   localparam logic [1:0] STATUS_NOT_PD  = 2'd2;

   localparam logic [6:0] SQRT_STEPS = 7'd32;
   localparam logic [6:0] DIV_STEPS  = 7'd64;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SYM_A,
      ST_SYM_B,
      ST_SYM_C,
      ST_F_A,
      ST_F_A2,
      ST_F_X,
      ST_F_Y,
      ST_F_M,
      ST_F_S,
      ST_F_ACC,
      ST_F_V,
      ST_F_RUN,
      ST_F_WAIT,
      ST_OUT_A,
      ST_OUT_B,
      ST_OUT_W,
      ST_ERR_W
   } state_type;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } sd_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/cholesky_decomposition.sv =====
// Cholesky factorization block: load, symmetry check, in-place factor, read-out.
// Uses chol_pkg and chol_sqdiv.
`timescale 1ns / 1ps
`default_nettype none
// The block takes an n-by-n matrix of signed fixed-point elements (FRAC_BITS
// fraction bits), one item per cycle in row-major order, with n set through the
// csr port (0 acts as 1, above MAX_SIZE acts as MAX_SIZE; a write restarts the
// load). After the last element req_ready drops while the block checks exact
// symmetry of each pair below the diagonal, factors the matrix in place and
// then emits L row-major, n*n items, one at a time, each held until rsp_ready
// takes it, last set on the final one. Each multiply-accumulate of the factor
// goes through a single 32x32 multiplier, each diagonal entry through a 32-step
// square root and each off-diagonal entry through a 64-step division in the
// shared iterative unit; a full 8x8 run's time is set mostly by that unit. An
// asymmetric matrix gives one item with status 1, a pivot that is not positive
// one item with status 2; either carries value/row/col zero, last set.
module cholesky_decomposition #(
   parameter int MAX_SIZE  = 8,
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_element,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_value,
   output logic [2:0]              rsp_row,
   output logic [2:0]              rsp_col,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last,
   input  wire logic               csr_write_enable,
   input  wire logic [3:0]         csr_write_data
);

   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [3:0] MAX_N = 4'(MAX_SIZE);

   function automatic logic [AW-1:0] addr_of(input logic [3:0] r, input logic [3:0] c);
      logic [7:0] lin;
      lin = 8'(r) * 8'(MAX_SIZE) + 8'(c);
      return lin[AW-1:0];
   endfunction

   // apply sign to a magnitude, saturate to 32 bits
   function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
      logic [31:0] r;
      if (neg) r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
      else     r = (mag >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      return r;
   endfunction

   chol_pkg::state_type state_ff, state_in;

   logic [3:0]  size_ff, size_in;
   logic [3:0]  ld_row_ff, ld_row_in;
   logic [3:0]  ld_col_ff, ld_col_in;
   logic [3:0]  row_ff, row_in;
   logic [3:0]  col_ff, col_in;
   logic [3:0]  k_ff, k_in;
   logic [3:0]  s_ff, s_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] d_ff, d_in;
   logic [31:0] v_ff, v_in;
   logic [31:0] term_ff, term_in;
   logic [35:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [2:0]  rsp_row_ff, rsp_row_in;
   logic [2:0]  rsp_col_ff, rsp_col_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_last_ff, rsp_last_in;

   // matrix store, one write and one registered read per cycle
   logic [31:0]   matrix_ff [DEPTH];
   logic [31:0]   rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [AW-1:0] mem_raddr;

   chol_pkg::sd_ctl_type sd_ctl;
   logic [63:0] sd_operand;
   logic        sd_done;
   logic [63:0] sd_result;

   logic [3:0]  n_eff;
   logic        in_acc;
   logic        ld_last;
   logic        out_last;
   logic        diag;
   logic        v_bad;
   logic [63:0] prod_mag;
   logic        prod_neg;
   logic [36:0] v_diff;
   logic [63:0] v_ext;
   logic [63:0] v_abs;

   always_comb begin
      if (size_ff == 4'd0)       n_eff = 4'd1;
      else if (size_ff > MAX_N)  n_eff = MAX_N;
      else                       n_eff = size_ff;
   end

   assign in_acc   = req_valid && (state_ff == chol_pkg::ST_IDLE);
   assign ld_last  = (ld_row_ff == n_eff - 4'd1) && (ld_col_ff == n_eff - 4'd1);
   assign out_last = (row_ff == n_eff - 4'd1) && (col_ff == n_eff - 4'd1);
   assign diag     = (row_ff == k_ff);
   assign v_bad    = v_ff[31] || (v_ff == 32'd0);

   // fixed-point product: truncate magnitude toward zero
   assign prod_neg = prod_ff[63];
   assign prod_mag = prod_neg ? (64'd0 - 64'(prod_ff)) : 64'(prod_ff);

   assign v_diff = {{5{a_ff[31]}}, a_ff} - {acc_ff[35], acc_ff};
   assign v_ext  = {{32{v_ff[31]}}, v_ff};
   assign v_abs  = v_ff[31] ? (64'd0 - v_ext) : v_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chol_pkg::ST_IDLE: begin
            if (req_valid && ld_last)
               state_in = (n_eff == 4'd1) ? chol_pkg::ST_F_A : chol_pkg::ST_SYM_A;
         end
         chol_pkg::ST_SYM_A: state_in = chol_pkg::ST_SYM_B;
         chol_pkg::ST_SYM_B: state_in = chol_pkg::ST_SYM_C;
         chol_pkg::ST_SYM_C: begin
            if (rdata_ff != a_ff)                     state_in = chol_pkg::ST_ERR_W;
            else if (col_ff + 4'd1 < row_ff)          state_in = chol_pkg::ST_SYM_A;
            else if (row_ff + 4'd1 < n_eff)           state_in = chol_pkg::ST_SYM_A;
            else                                      state_in = chol_pkg::ST_F_A;
         end
         chol_pkg::ST_F_A:  state_in = chol_pkg::ST_F_A2;
         chol_pkg::ST_F_A2: state_in = (k_ff == 4'd0) ? chol_pkg::ST_F_V : chol_pkg::ST_F_X;
         chol_pkg::ST_F_X:  state_in = chol_pkg::ST_F_Y;
         chol_pkg::ST_F_Y:  state_in = chol_pkg::ST_F_M;
         chol_pkg::ST_F_M:  state_in = chol_pkg::ST_F_S;
         chol_pkg::ST_F_S:  state_in = chol_pkg::ST_F_ACC;
         chol_pkg::ST_F_ACC:
            state_in = (s_ff + 4'd1 == k_ff) ? chol_pkg::ST_F_V : chol_pkg::ST_F_X;
         chol_pkg::ST_F_V:  state_in = chol_pkg::ST_F_RUN;
         chol_pkg::ST_F_RUN:
            state_in = (diag && v_bad) ? chol_pkg::ST_ERR_W : chol_pkg::ST_F_WAIT;
         chol_pkg::ST_F_WAIT: begin
            if (sd_done) begin
               if (row_ff + 4'd1 < n_eff)     state_in = chol_pkg::ST_F_A;
               else if (k_ff + 4'd1 < n_eff)  state_in = chol_pkg::ST_F_A;
               else                           state_in = chol_pkg::ST_OUT_A;
            end
         end
         chol_pkg::ST_OUT_A: state_in = chol_pkg::ST_OUT_B;
         chol_pkg::ST_OUT_B: state_in = chol_pkg::ST_OUT_W;
         chol_pkg::ST_OUT_W: begin
            if (rsp_ready) state_in = rsp_last_ff ? chol_pkg::ST_IDLE : chol_pkg::ST_OUT_A;
         end
         chol_pkg::ST_ERR_W: begin
            if (rsp_ready) state_in = chol_pkg::ST_IDLE;
         end
         default: state_in = chol_pkg::ST_IDLE;
      endcase
   end

   // memory ports and shared unit control
   always_comb begin
      mem_we        = 1'b0;
      mem_waddr     = addr_of(row_ff, k_ff);
      mem_wdata     = 32'd0;
      mem_raddr     = addr_of(row_ff, col_ff);
      sd_ctl.start   = 1'b0;
      sd_ctl.is_sqrt = diag;
      sd_operand    = diag ? ({32'd0, v_ff} << FRAC_BITS) : (v_abs << FRAC_BITS);
      case (state_ff)
         chol_pkg::ST_IDLE: begin
            mem_we    = in_acc;
            mem_waddr = addr_of(ld_row_ff, ld_col_ff);
            mem_wdata = req_element;
         end
         chol_pkg::ST_SYM_B: mem_raddr = addr_of(col_ff, row_ff);
         chol_pkg::ST_F_A:   mem_raddr = addr_of(row_ff, k_ff);
         chol_pkg::ST_F_X:   mem_raddr = addr_of(row_ff, s_ff);
         chol_pkg::ST_F_Y:   mem_raddr = addr_of(k_ff, s_ff);
         chol_pkg::ST_F_RUN: sd_ctl.start = !(diag && v_bad);
         chol_pkg::ST_F_WAIT: begin
            mem_we    = sd_done;
            mem_wdata = diag ? sd_result[31:0] : sat_mag(v_ff[31], sd_result);
         end
         default: ;
      endcase
   end

   // datapath and counters
   always_comb begin
      size_in       = size_ff;
      ld_row_in     = ld_row_ff;
      ld_col_in     = ld_col_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      k_in          = k_ff;
      s_in          = s_ff;
      a_in          = a_ff;
      x_in          = x_ff;
      d_in          = d_ff;
      v_in          = v_ff;
      term_in       = term_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_write_enable) begin
         size_in   = csr_write_data;
         ld_row_in = 4'd0;
         ld_col_in = 4'd0;
      end

      case (state_ff)
         chol_pkg::ST_IDLE: begin
            if (in_acc) begin
               if (ld_last) begin
                  ld_row_in = 4'd0;
                  ld_col_in = 4'd0;
                  row_in    = (n_eff == 4'd1) ? 4'd0 : 4'd1;
                  col_in    = 4'd0;
                  k_in      = 4'd0;
               end else if (ld_col_ff == n_eff - 4'd1) begin
                  ld_col_in = 4'd0;
                  ld_row_in = ld_row_ff + 4'd1;
               end else begin
                  ld_col_in = ld_col_ff + 4'd1;
               end
            end
         end
         chol_pkg::ST_SYM_B: a_in = rdata_ff;
         chol_pkg::ST_SYM_C: begin
            if (rdata_ff != a_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = 32'd0;
               rsp_row_in    = 3'd0;
               rsp_col_in    = 3'd0;
               rsp_status_in = chol_pkg::STATUS_NOT_SYM;
               rsp_last_in   = 1'b1;
            end else if (col_ff + 4'd1 < row_ff) begin
               col_in = col_ff + 4'd1;
            end else if (row_ff + 4'd1 < n_eff) begin
               row_in = row_ff + 4'd1;
               col_in = 4'd0;
            end else begin
               row_in = 4'd0;
               k_in   = 4'd0;
            end
         end
         chol_pkg::ST_F_A: begin
            acc_in = '0;
            s_in   = 4'd0;
         end
         chol_pkg::ST_F_A2: a_in = rdata_ff;
         chol_pkg::ST_F_Y:  x_in = rdata_ff;
         chol_pkg::ST_F_M:  prod_in = $signed(x_ff) * $signed(rdata_ff);
         chol_pkg::ST_F_S:  term_in = sat_mag(prod_neg, prod_mag >> FRAC_BITS);
         chol_pkg::ST_F_ACC: begin
            acc_in = acc_ff + {{4{term_ff[31]}}, term_ff};
            s_in   = s_ff + 4'd1;
         end
         chol_pkg::ST_F_V: begin
            if (v_diff[36:31] == 6'b000000 || v_diff[36:31] == 6'b111111)
               v_in = v_diff[31:0];
            else
               v_in = v_diff[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
         chol_pkg::ST_F_RUN: begin
            if (diag && v_bad) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = 32'd0;
               rsp_row_in    = 3'd0;
               rsp_col_in    = 3'd0;
               rsp_status_in = chol_pkg::STATUS_NOT_PD;
               rsp_last_in   = 1'b1;
            end
         end
         chol_pkg::ST_F_WAIT: begin
            if (sd_done) begin
               if (diag) d_in = sd_result[31:0];
               if (row_ff + 4'd1 < n_eff) begin
                  row_in = row_ff + 4'd1;
               end else if (k_ff + 4'd1 < n_eff) begin
                  k_in   = k_ff + 4'd1;
                  row_in = k_ff + 4'd1;
               end else begin
                  row_in = 4'd0;
                  col_in = 4'd0;
               end
            end
         end
         chol_pkg::ST_OUT_B: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = (col_ff <= row_ff) ? rdata_ff : 32'd0;
            rsp_row_in    = row_ff[2:0];
            rsp_col_in    = col_ff[2:0];
            rsp_status_in = chol_pkg::STATUS_OK;
            rsp_last_in   = out_last;
         end
         chol_pkg::ST_OUT_W: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (col_ff == n_eff - 4'd1) begin
                  col_in = 4'd0;
                  row_in = row_ff + 4'd1;
               end else begin
                  col_in = col_ff + 4'd1;
               end
            end
         end
         chol_pkg::ST_ERR_W: begin
            if (rsp_ready) rsp_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chol_pkg::ST_IDLE;
         size_ff      <= 4'd8;
         ld_row_ff    <= 4'd0;
         ld_col_ff    <= 4'd0;
         row_ff       <= 4'd0;
         col_ff       <= 4'd0;
         k_ff         <= 4'd0;
         s_ff         <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         ld_row_ff    <= ld_row_in;
         ld_col_ff    <= ld_col_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         s_ff         <= s_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff          <= a_in;
      x_ff          <= x_in;
      d_ff          <= d_in;
      v_ff          <= v_in;
      term_ff       <= term_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) matrix_ff[mem_waddr] <= mem_wdata;
      rdata_ff <= matrix_ff[mem_raddr];
   end

   chol_sqdiv u_sqdiv (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sd_ctl),
      .operand (sd_operand),
      .divisor (d_ff),
      .done    (sd_done),
      .result  (sd_result)
   );

   assign req_ready  = (state_ff == chol_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/chol_sqdiv.sv =====
// Iterative unsigned divider / integer square root sharing one subtractor.
// Uses chol_pkg (control struct, step counts).
`timescale 1ns / 1ps
`default_nettype none
module chol_sqdiv (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire chol_pkg::sd_ctl_type ctl,
   input  wire logic [63:0]        operand,
   input  wire logic [31:0]        divisor,
   output logic                    done,
   output logic [63:0]             result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        sqrt_ff, sqrt_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in;
   logic [35:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic [31:0] den_ff, den_in;

   logic [35:0] cand;
   logic [35:0] trial;
   logic [36:0] diff;
   logic        ge;

   // one restoring step: radix 4 for root, radix 2 for quotient
   always_comb begin
      if (sqrt_ff) begin
         cand  = {rem_ff[33:0], x_ff[63:62]};
         trial = {2'b00, q_ff[31:0], 2'b01};
      end else begin
         cand  = {rem_ff[34:0], x_ff[63]};
         trial = {4'b0000, den_ff};
      end
      diff = {1'b0, cand} - {1'b0, trial};
      ge   = ~diff[36];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         sqrt_in = ctl.is_sqrt;
         cnt_in  = ctl.is_sqrt ? chol_pkg::SQRT_STEPS : chol_pkg::DIV_STEPS;
         x_in    = operand;
         rem_in  = '0;
         q_in    = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[35:0] : cand;
         q_in   = {q_ff[62:0], ge};
         x_in   = sqrt_ff ? {x_ff[61:0], 2'b00} : {x_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sqrt_ff <= sqrt_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      den_ff  <= den_in;
   end

   assign done   = done_ff;
   assign result = q_ff;

endmodule
`default_nettype wire

// ===== tb/cholesky_decomposition_test.sv =====
// Self-checking testbench for cholesky_decomposition: loads matrices, predicts
// the lower factor or error item and checks each result. Needs chol_pkg and the RTL.
`timescale 1ns / 1ps

module cholesky_decomposition_test;

   localparam int MAXN = 8;
   localparam int FRAC = 16;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] value;
      logic [2:0]         row;
      logic [2:0]         col;
      logic [1:0]         status;
      logic               is_last;
   } factor_item_type;

   // Scoreboard: keeps its own copy of the matrix store and the size register.
   class factor_board;
      int unsigned      size_reg = 8;
      int unsigned      loaded;
      longint           mat[MAXN*MAXN];
      factor_item_type  expected_q[$];
      int               errors;
      int               checked;
      int               runs_ok, runs_sym, runs_pd;

      function int unsigned eff_size();
         if (size_reg < 1) return 1;
         if (size_reg > MAXN) return MAXN;
         return size_reg;
      endfunction

      function void set_size(int unsigned v);
         size_reg = v;
         loaded = 0;
      endfunction

      function longint clamp32(longint x);
         if (x > S32_MAX) return S32_MAX;
         if (x < S32_MIN) return S32_MIN;
         return x;
      endfunction

      function longint apply_sign(bit neg, longint unsigned mag);
         if (neg) return (mag >= 64'd2147483648) ? S32_MIN : -longint'(mag);
         return (mag >= 64'd2147483647) ? S32_MAX : longint'(mag);
      endfunction

      function longint fx_mul(longint a, longint b);
         longint p;
         longint unsigned mag;
         p = a * b;
         mag = (p < 0) ? longint'(-p) : p;
         return apply_sign(p < 0, mag >> FRAC);
      endfunction

      function longint fx_div(longint num, longint den);
         longint unsigned mag;
         mag = (num < 0) ? longint'(-num) : num;
         mag = (mag << FRAC) / longint'(den);
         return apply_sign(num < 0, mag);
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x = x - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      // a(r,c) minus the dot product of rows r and k over the first k columns
      function longint reduced(int r, int k, int c);
         longint acc;
         acc = 0;
         for (int s = 0; s < k; s++) acc += fx_mul(mat[r*MAXN+s], mat[k*MAXN+s]);
         return clamp32(mat[r*MAXN+c] - acc);
      endfunction

      function void push_error(logic [1:0] code);
         factor_item_type it;
         it.value = 0; it.row = 0; it.col = 0; it.status = code; it.is_last = 1;
         expected_q.push_back(it);
      endfunction

      function void factor(int n);
         longint v, d;
         factor_item_type it;
         for (int r = 0; r < n; r++)
            for (int c = 0; c < r; c++)
               if (mat[r*MAXN+c] != mat[c*MAXN+r]) begin
                  push_error(chol_pkg::STATUS_NOT_SYM);
                  runs_sym++;
                  return;
               end
         for (int k = 0; k < n; k++) begin
            v = reduced(k, k, k);
            if (v <= 0) begin
               push_error(chol_pkg::STATUS_NOT_PD);
               runs_pd++;
               return;
            end
            d = longint'(int_sqrt(longint'(v) << FRAC));
            mat[k*MAXN+k] = clamp32(d);
            for (int i = k + 1; i < n; i++)
               mat[i*MAXN+k] = clamp32(fx_div(reduced(i, k, k), d));
         end
         for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
               it.value = (c <= r) ? mat[r*MAXN+c] : 0;
               it.row = r;
               it.col = c;
               it.status = chol_pkg::STATUS_OK;
               it.is_last = (r == n - 1) && (c == n - 1);
               expected_q.push_back(it);
            end
         runs_ok++;
      endfunction

      // Accepted input element; a full matrix triggers the prediction.
      function void note_element(logic signed [31:0] e);
         int unsigned n;
         n = eff_size();
         if (loaded >= n * n) loaded = 0;
         mat[(loaded / n) * MAXN + (loaded % n)] = e;
         loaded++;
         if (loaded < n * n) return;
         loaded = 0;
         factor(n);
      endfunction

      function void check_result(factor_item_type got);
         factor_item_type exp_it;
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result value=%h row=%0d col=%0d status=%0d last=%0d",
                     $time, got.value, got.row, got.col, got.status, got.is_last);
            return;
         end
         exp_it = expected_q.pop_front();
         if (got.value !== exp_it.value || got.row !== exp_it.row ||
             got.col !== exp_it.col || got.status !== exp_it.status ||
             got.is_last !== exp_it.is_last) begin
            errors++;
            $display({"%0t: mismatch expected value=%h row=%0d col=%0d status=%0d",
                      " last=%0d, actual value=%h row=%0d col=%0d status=%0d last=%0d"},
                     $time, exp_it.value, exp_it.row, exp_it.col, exp_it.status,
                     exp_it.is_last, got.value, got.row, got.col, got.status,
                     got.is_last);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [31:0] req_element = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_value;
   logic [2:0] rsp_row;
   logic [2:0] rsp_col;
   logic [1:0] rsp_status;
   logic rsp_last;
   logic csr_write_enable = 0;
   logic [3:0] csr_write_data = 0;

   factor_board sb = new();

   // idle percentages per side, changed by the stimulus between phases
   int send_idle_pct = 8;
   int recv_idle_pct = 84;
   bit hold_request = 0;   // asks the receiver for one long hold-off
   int hold_left = 0;
   int items_sent = 0;

   logic signed [31:0] mtx[MAXN*MAXN];   // matrix being sent, row-major

   cholesky_decomposition dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_element(req_element),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_value(rsp_value),
      .rsp_row(rsp_row),
      .rsp_col(rsp_col),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   // Receiver: ready is changed on the falling edge; the long hold-off is
   // counted here so the sender keeps pushing while results back up.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = 4000;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result sampling at the rising edge, before the block updates.
   always @(posedge clock) begin
      factor_item_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.value = rsp_value;
         got.row = rsp_row;
         got.col = rsp_col;
         got.status = rsp_status;
         got.is_last = rsp_last;
         sb.check_result(got);
      end
   end

   // One element: random idle cycles, then hold valid until accepted.
   task automatic send_element(logic signed [31:0] e);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_element = e;
      do @(posedge clock); while (!req_ready);
      sb.note_element(e);
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_matrix(int n);
      for (int i = 0; i < n * n; i++) send_element(mtx[(i / n) * MAXN + (i % n)]);
   endtask

   // Wait until every expected item is back, then a margin so the block is idle.
   task automatic wait_drained();
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_size(logic [3:0] v);
      wait_drained();
      csr_write_enable = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.set_size(v);
   endtask

   // Matrix kinds for random runs
   typedef enum int {MK_GOOD, MK_ASYM, MK_NOT_PD, MK_EXTREME, MK_NOISE} matrix_kind_type;

   // Fill mtx; good matrices are symmetric and diagonally dominant so the
   // factor usually completes, the rest exercise errors and saturation.
   task automatic build_matrix(int n, matrix_kind_type kind);
      int r2, c2;
      for (int r = 0; r < n; r++)
         for (int c = 0; c <= r; c++) begin
            case (kind)
               MK_NOISE: begin
                  mtx[r*MAXN+c] = $urandom;
                  mtx[c*MAXN+r] = $urandom;
               end
               MK_EXTREME: begin
                  mtx[r*MAXN+c] = (r == c) ? 32'sh7fffffff :
                     (($urandom_range(1)) ? 32'sh80000000 : 32'sh7fffffff);
                  mtx[c*MAXN+r] = mtx[r*MAXN+c];
               end
               default: begin
                  if (r == c)
                     mtx[r*MAXN+c] = n * (1 << 18) + $urandom_range(1 << 20);
                  else
                     mtx[r*MAXN+c] = $signed($urandom_range(1 << 19)) - (1 << 18);
                  mtx[c*MAXN+r] = mtx[r*MAXN+c];
               end
            endcase
         end
      if (kind == MK_ASYM && n > 1) begin
         r2 = $urandom_range(n - 1, 1);
         c2 = $urandom_range(r2 - 1);
         mtx[r2*MAXN+c2] = mtx[c2*MAXN+r2] ^ (32'h1 << $urandom_range(31));
      end
      if (kind == MK_NOT_PD) begin
         r2 = $urandom_range(n - 1);
         mtx[r2*MAXN+r2] = -$signed($urandom_range(1 << 20));
      end
   endtask

   function automatic int eff_of(logic [3:0] v);
      return (v == 0) ? 1 : (v > MAXN) ? MAXN : v;
   endfunction

   initial begin
      logic [3:0] cur_size;
      logic [3:0] new_size;
      int pick;
      int n;
      int matrices;
      matrix_kind_type kind;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: 1x1 extremes (largest, most negative, zero pivot, tiny).
      write_size(4'd1);
      send_element(32'sh7fffffff);
      send_element(32'sh80000000);
      send_element(32'sh00000000);
      send_element(32'sh00000001);
      // 2x2: well formed, asymmetric, second pivot zero.
      write_size(4'd2);
      mtx[0] = 32'sh00040000; mtx[1] = 32'sh00010000;
      mtx[8] = 32'sh00010000; mtx[9] = 32'sh00030000;
      send_matrix(2);
      mtx[1] = 32'sh00010001;
      send_matrix(2);
      mtx[0] = 32'sh00010000; mtx[1] = 32'sh00010000;
      mtx[8] = 32'sh00010000; mtx[9] = 32'sh00010000;
      send_matrix(2);
      // 3x3 with extremes off the diagonal saturates products and quotients.
      write_size(4'd3);
      build_matrix(3, MK_EXTREME);
      send_matrix(3);

      // Random part in three idling phases.
      cur_size = 4'd3;
      matrices = 0;
      while (items_sent < 118) begin
         if (items_sent >= 104) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end else if (items_sent >= 89) begin
            send_idle_pct = 84; recv_idle_pct = 8;
         end
         pick = $urandom_range(99);
         new_size = (pick < 10) ? 4'd0 : (pick < 20) ? 4'd1 : 4'($urandom_range(4, 2));
         if (matrices == 0) new_size = 4'd15;   // full size once early, out of range
         if (new_size != cur_size) begin
            write_size(new_size);
            cur_size = new_size;
         end
         n = eff_of(cur_size);
         pick = $urandom_range(99);
         kind = (pick < 70) ? MK_GOOD : (pick < 80) ? MK_ASYM : (pick < 88) ? MK_NOT_PD :
                (pick < 94) ? MK_EXTREME : MK_NOISE;
         build_matrix(n, kind);
         // Long receiver hold-off while the sender keeps offering the next matrix.
         if (matrices == 1) hold_request = 1;
         send_matrix(n);
         // Sender pause until everything outstanding has come back.
         if (matrices == 2) wait_drained();
         matrices++;
      end

      wait_drained();
      repeat (50) @(negedge clock);
      $display("Sent %0d elements; factors ok %0d, asymmetric %0d, not positive %0d.",
               items_sent, sb.runs_ok, sb.runs_sym, sb.runs_pd);
      $display("Checked %0d result items across sizes 1 to 8 and three idle mixes.",
               sb.checked);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/chol_pkg.sv
rtl/chol_sqdiv.sv
rtl/cholesky_decomposition.sv
tb/cholesky_decomposition_test.sv
